>>> rtl/fprls_pkg.sv
package fprls_pkg;

   localparam int POWER_WIDTH = 12;
   localparam logic [15:0] POWER_MAX = 16'((2 ** POWER_WIDTH) - 1);
   localparam logic [6:0] LEVEL_MAX = 7'd100;
   localparam logic [6:0] PRIORITY_MAX = 7'd100;
   localparam logic [7:0] ESC_FLIP = 8'h80;

   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);

   localparam int REPLY_BYTES = 5;
   localparam int BYTE_IDX_W = $clog2(REPLY_BYTES);

   typedef enum logic [1:0] {
      KIND_LINK = 2'd0,
      KIND_LEVEL = 2'd1,
      KIND_POWER = 2'd2,
      KIND_PRIORITY = 2'd3
   } in_kind_type;

   typedef enum logic [7:0] {
      REG_GROUP_ID = 8'd0,
      REG_NODE_ID = 8'd1,
      REG_POLL_CODE = 8'd2,
      REG_REPLY_CODE = 8'd3,
      REG_START_CODE = 8'd4,
      REG_ESCAPE_CODE = 8'd5,
      REG_END_CODE = 8'd6,
      REG_HYSTERESIS = 8'd7
   } reg_index_type;

   localparam logic OUT_KIND_REPLY = 1'b0;
   localparam logic OUT_KIND_REPORT = 1'b1;

   typedef struct packed {
      logic [7:0] group_id;
      logic [7:0] node_id;
      logic [7:0] poll_code;
      logic [7:0] reply_code;
      logic [7:0] start_code;
      logic [7:0] escape_code;
      logic [7:0] end_code;
      logic [6:0] hysteresis;
   } cfg_type;

   typedef struct packed {
      logic is_reply;
      logic switch_on;
      logic [POWER_WIDTH-1:0] power;
   } job_type;

   typedef struct packed {
      logic valid;
      job_type job;
   } job_push_type;

endpackage

>>> rtl/framed_poll_responder_load_switch.sv
// Channel   Handshake                Payload
// req       req_push / req_full      kind, link_byte, level_sample, setting_value
// rsp       rsp_pop / rsp_empty      out_kind, reply_byte, last, switch_on
// csr       csr_valid / csr_ready    csr_index, csr_data
//
// One input transfer is taken per cycle while the job queue has room.
// A level tick yields one result and a matching poll yields five, one per cycle
// from the output register while rsp_pop keeps taking them.
// The four-entry job queue lets the input side run on while the result side stalls.
// Reset is synchronous and clears the deframer, the queue and the output valid flag and byte index.
module framed_poll_responder_load_switch (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [1:0] req_kind,
   input logic [7:0] req_link_byte,
   input logic [7:0] req_level_sample,
   input logic [15:0] req_setting_value,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic rsp_out_kind,
   output logic [7:0] rsp_reply_byte,
   output logic rsp_last,
   output logic rsp_switch_on,
   input logic csr_valid,
   output logic csr_ready,
   input logic [7:0] csr_index,
   input logic [7:0] csr_data
);
   import fprls_pkg::*;

   cfg_type cfg;
   job_push_type push;
   job_type head;
   logic head_valid;
   logic head_pop;
   logic accept;

   assign accept = req_push && !req_full;

   fprls_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   fprls_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .accept(accept),
      .kind(req_kind),
      .link_byte(req_link_byte),
      .level_sample(req_level_sample),
      .setting_value(req_setting_value),
      .push(push)
   );

   fprls_jobq u_jobq (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(req_full),
      .pop(head_pop),
      .head_valid(head_valid),
      .head(head)
   );

   fprls_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .head_valid(head_valid),
      .head(head),
      .head_pop(head_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_kind(rsp_out_kind),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_last(rsp_last),
      .rsp_switch_on(rsp_switch_on)
   );

endmodule

>>> rtl/fprls_csr.sv
module fprls_csr (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   output logic csr_ready,
   input logic [7:0] csr_index,
   input logic [7:0] csr_data,
   output fprls_pkg::cfg_type cfg
);
   import fprls_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GROUP_ID: cfg_in.group_id = csr_data;
            REG_NODE_ID: cfg_in.node_id = csr_data;
            REG_POLL_CODE: cfg_in.poll_code = csr_data;
            REG_REPLY_CODE: cfg_in.reply_code = csr_data;
            REG_START_CODE: cfg_in.start_code = csr_data;
            REG_ESCAPE_CODE: cfg_in.escape_code = csr_data;
            REG_END_CODE: cfg_in.end_code = csr_data;
            REG_HYSTERESIS: cfg_in.hysteresis = csr_data[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_id <= 8'd0;
         cfg_ff.node_id <= 8'd0;
         cfg_ff.poll_code <= 8'd0;
         cfg_ff.reply_code <= 8'd0;
         cfg_ff.start_code <= 8'd2;
         cfg_ff.escape_code <= 8'd16;
         cfg_ff.end_code <= 8'd3;
         cfg_ff.hysteresis <= 7'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/fprls_front.sv
module fprls_front (
   input logic clock,
   input logic reset,
   input fprls_pkg::cfg_type cfg,
   input logic accept,
   input logic [1:0] kind,
   input logic [7:0] link_byte,
   input logic [7:0] level_sample,
   input logic [15:0] setting_value,
   output fprls_pkg::job_push_type push
);
   import fprls_pkg::*;

   typedef enum logic [2:0] {
      ST_WAIT = 3'b001,
      ST_DATA = 3'b010,
      ST_ESC = 3'b100
   } frame_state_type;

   frame_state_type state_ff, state_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] group_ff, group_in;
   logic [7:0] node_ff, node_in;
   logic [7:0] type_ff, type_in;
   logic [POWER_WIDTH-1:0] power_ff, power_in;
   logic [6:0] priority_ff, priority_in;
   logic switch_ff, switch_in;

   logic keep;
   logic [7:0] keep_byte;
   logic frame_end;
   logic [6:0] level;
   logic [6:0] thr;
   logic [7:0] level_hyst;

   assign level = (level_sample > 8'(LEVEL_MAX)) ? LEVEL_MAX : level_sample[6:0];
   assign thr = LEVEL_MAX - priority_ff;
   assign level_hyst = {1'b0, level} + {1'b0, cfg.hysteresis};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      group_in = group_ff;
      node_in = node_ff;
      type_in = type_ff;
      power_in = power_ff;
      priority_in = priority_ff;
      switch_in = switch_ff;
      keep = 1'b0;
      keep_byte = link_byte;
      frame_end = 1'b0;
      push = '0;

      if (accept) begin
         case (in_kind_type'(kind))
            KIND_LINK: begin
               case (state_ff)
                  ST_WAIT: begin
                     if (link_byte == cfg.start_code) begin
                        state_in = ST_DATA;
                     end
                  end
                  ST_DATA: begin
                     if (link_byte == cfg.escape_code) begin
                        state_in = ST_ESC;
                     end else if (link_byte == cfg.end_code) begin
                        frame_end = 1'b1;
                     end else begin
                        keep = 1'b1;
                     end
                  end
                  ST_ESC: begin
                     keep = 1'b1;
                     keep_byte = link_byte ^ ESC_FLIP;
                     state_in = ST_DATA;
                  end
                  default: state_in = ST_WAIT;
               endcase
            end
            KIND_LEVEL: begin
               if (priority_ff == 7'd0 || power_ff == '0) begin
                  switch_in = 1'b0;
               end else if (priority_ff == PRIORITY_MAX || level >= thr) begin
                  switch_in = 1'b1;
               end else if (level == 7'd0 || level_hyst < {1'b0, thr}) begin
                  switch_in = 1'b0;
               end
               push.valid = 1'b1;
               push.job.is_reply = 1'b0;
               push.job.switch_on = switch_in;
            end
            KIND_POWER: begin
               if (setting_value <= POWER_MAX) begin
                  power_in = setting_value[POWER_WIDTH-1:0];
               end
            end
            KIND_PRIORITY: begin
               if (setting_value <= 16'(PRIORITY_MAX)) begin
                  priority_in = setting_value[6:0];
               end
            end
            default: state_in = state_ff;
         endcase
      end

      if (keep) begin
         case (count_ff)
            2'd0: group_in = keep_byte;
            2'd1: node_in = keep_byte;
            2'd2: type_in = keep_byte;
            default: type_in = type_ff;
         endcase
         if (count_ff != 2'd3) begin
            count_in = count_ff + 2'd1;
         end
      end

      if (frame_end) begin
         state_in = ST_WAIT;
         count_in = 2'd0;
         if (type_ff == cfg.poll_code && group_ff == cfg.group_id
               && node_ff == cfg.node_id) begin
            push.valid = 1'b1;
            push.job.is_reply = 1'b1;
            push.job.switch_on = switch_ff;
            push.job.power = switch_ff ? power_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         count_ff <= 2'd0;
         group_ff <= 8'd0;
         node_ff <= 8'd0;
         type_ff <= 8'd0;
         power_ff <= '0;
         priority_ff <= PRIORITY_MAX;
         switch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         group_ff <= group_in;
         node_ff <= node_in;
         type_ff <= type_in;
         power_ff <= power_in;
         priority_ff <= priority_in;
         switch_ff <= switch_in;
      end
   end

endmodule

>>> rtl/fprls_jobq.sv
module fprls_jobq (
   input logic clock,
   input logic reset,
   input fprls_pkg::job_push_type push,
   output logic full,
   input logic pop,
   output logic head_valid,
   output fprls_pkg::job_type head
);
   import fprls_pkg::*;

   job_type entry_ff [JOBQ_DEPTH];
   logic [JOBQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOBQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOBQ_AW:0] count_ff, count_in;
   logic do_pop;

   assign full = (count_ff == (JOBQ_AW + 1)'(JOBQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head = entry_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/fprls_back.sv
module fprls_back (
   input logic clock,
   input logic reset,
   input fprls_pkg::cfg_type cfg,
   input logic head_valid,
   input fprls_pkg::job_type head,
   output logic head_pop,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic rsp_out_kind,
   output logic [7:0] rsp_reply_byte,
   output logic rsp_last,
   output logic rsp_switch_on
);
   import fprls_pkg::*;

   logic valid_ff, valid_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;
   logic switch_ff, switch_in;
   logic load;
   logic [15:0] pw;

   assign rsp_empty = !valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_reply_byte = byte_ff;
   assign rsp_last = last_ff;
   assign rsp_switch_on = switch_ff;

   assign load = head_valid && (!valid_ff || rsp_pop);
   assign pw = 16'(head.power);

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      kind_in = kind_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      switch_in = switch_ff;
      head_pop = 1'b0;

      if (valid_ff && rsp_pop) begin
         valid_in = 1'b0;
      end

      if (load) begin
         valid_in = 1'b1;
         switch_in = head.switch_on;
         if (head.is_reply) begin
            kind_in = OUT_KIND_REPLY;
            last_in = 1'b0;
            case (idx_ff)
               BYTE_IDX_W'(0): byte_in = cfg.group_id;
               BYTE_IDX_W'(1): byte_in = cfg.node_id;
               BYTE_IDX_W'(2): byte_in = cfg.reply_code;
               BYTE_IDX_W'(3): byte_in = pw[15:8];
               default: byte_in = pw[7:0];
            endcase
            if (idx_ff == BYTE_IDX_W'(REPLY_BYTES - 1)) begin
               last_in = 1'b1;
               idx_in = '0;
               head_pop = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            kind_in = OUT_KIND_REPORT;
            byte_in = 8'd0;
            last_in = 1'b1;
            head_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      switch_ff <= switch_in;
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import fprls_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_ITEMS = 48;
   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_CYCLES = 10;

   typedef enum logic [2:0] {
      DF_HUNT = 3'b001,
      DF_BODY = 3'b010,
      DF_ESCAPED = 3'b100
   } deframe_state_type;

   typedef struct packed {
      logic out_kind;
      logic [7:0] reply_byte;
      logic last;
      logic switch_on;
   } rsp_item_type;

   typedef struct {
      in_kind_type kind;
      logic [7:0] link_byte;
      logic [7:0] level;
      logic [15:0] setting;
      bit known;
      logic known_sw;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic [1:0] req_kind;
   logic [7:0] req_link_byte;
   logic [7:0] req_level_sample;
   logic [15:0] req_setting_value;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_out_kind;
   logic [7:0] rsp_reply_byte;
   logic rsp_last;
   logic rsp_switch_on;
   logic csr_valid;
   logic csr_ready;
   logic [7:0] csr_index;
   logic [7:0] csr_data;

   framed_poll_responder_load_switch u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_kind(req_kind),
      .req_link_byte(req_link_byte),
      .req_level_sample(req_level_sample),
      .req_setting_value(req_setting_value),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_kind(rsp_out_kind),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_last(rsp_last),
      .rsp_switch_on(rsp_switch_on),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the configuration and of the block's state.
   cfg_type cfg_shadow;
   deframe_state_type df_state;
   logic [1:0] payload_cnt;
   logic [7:0] hdr_group;
   logic [7:0] hdr_node;
   logic [7:0] hdr_type;
   logic [POWER_WIDTH-1:0] power_lvl;
   logic [6:0] prio_lvl;
   logic sw_on;

   rsp_item_type pending_rsp[$];

   int cycle_cnt = 0;
   int err_cnt = 0;
   int n_in = 0;
   int n_rsp = 0;
   int n_replies = 0;
   int n_csr = 0;
   int n_full_cycles = 0;
   bit no_idle = 1'b0;
   bit hold_req = 1'b0;

   stim_row_type dir_tab [28] = '{
      '{KIND_LEVEL,    8'h00, 8'h00, 16'h0000, 1'b1, 1'b0},
      '{KIND_LEVEL,    8'hff, 8'hff, 16'hffff, 1'b1, 1'b0},
      '{KIND_POWER,    8'h00, 8'h00, 16'hffff, 1'b0, 1'b0},
      '{KIND_POWER,    8'hff, 8'h00, 16'h0fff, 1'b0, 1'b0},
      '{KIND_PRIORITY, 8'h00, 8'hff, 16'h0065, 1'b0, 1'b0},
      '{KIND_LEVEL,    8'h00, 8'hff, 16'h0000, 1'b1, 1'b1},
      '{KIND_LINK,     8'h02, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h00, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h00, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h00, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h03, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h02, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h10, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h83, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h10, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h90, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h02, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'haa, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h03, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h02, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h00, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LINK,     8'h03, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_PRIORITY, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{KIND_LEVEL,    8'h00, 8'h64, 16'h0000, 1'b1, 1'b0},
      '{KIND_PRIORITY, 8'h00, 8'h00, 16'h0032, 1'b0, 1'b0},
      '{KIND_LEVEL,    8'h00, 8'h32, 16'h0000, 1'b0, 1'b0},
      '{KIND_LEVEL,    8'h00, 8'h2e, 16'h0000, 1'b0, 1'b0},
      '{KIND_LEVEL,    8'h00, 8'h2c, 16'h0000, 1'b0, 1'b0}
   };

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic push_rsp(logic okind, logic [7:0] b, logic is_last);
      pending_rsp.push_back('{okind, b, is_last, sw_on});
   endtask

   task automatic store_payload(logic [7:0] b);
      case (payload_cnt)
         2'd0: hdr_group = b;
         2'd1: hdr_node = b;
         2'd2: hdr_type = b;
         default: ;
      endcase
      if (payload_cnt != 2'd3) begin
         payload_cnt++;
      end
   endtask

   task automatic predict_item(in_kind_type k, logic [7:0] lb, logic [7:0] lv,
                               logic [15:0] sv, bit quiet);
      int lvl;
      int thr;
      logic [15:0] pw;
      case (k)
         KIND_LINK: begin
            if (df_state == DF_HUNT) begin
               if (lb == cfg_shadow.start_code) begin
                  df_state = DF_BODY;
               end
            end else if (df_state == DF_BODY) begin
               if (lb == cfg_shadow.escape_code) begin
                  df_state = DF_ESCAPED;
               end else if (lb == cfg_shadow.end_code) begin
                  df_state = DF_HUNT;
                  payload_cnt = 2'd0;
                  if (hdr_type == cfg_shadow.poll_code && hdr_group == cfg_shadow.group_id &&
                      hdr_node == cfg_shadow.node_id) begin
                     pw = sw_on ? 16'(power_lvl) : 16'h0000;
                     push_rsp(OUT_KIND_REPLY, cfg_shadow.group_id, 1'b0);
                     push_rsp(OUT_KIND_REPLY, cfg_shadow.node_id, 1'b0);
                     push_rsp(OUT_KIND_REPLY, cfg_shadow.reply_code, 1'b0);
                     push_rsp(OUT_KIND_REPLY, pw[15:8], 1'b0);
                     push_rsp(OUT_KIND_REPLY, pw[7:0], 1'b1);
                     n_replies++;
                  end
               end else begin
                  store_payload(lb);
               end
            end else begin
               store_payload(lb ^ ESC_FLIP);
               df_state = DF_BODY;
            end
         end
         KIND_LEVEL: begin
            lvl = (lv > 8'(LEVEL_MAX)) ? int'(LEVEL_MAX) : int'(lv);
            thr = int'(LEVEL_MAX) - int'(prio_lvl);
            if (prio_lvl == 7'd0 || power_lvl == '0) begin
               sw_on = 1'b0;
            end else if (prio_lvl == PRIORITY_MAX || lvl >= thr) begin
               sw_on = 1'b1;
            end else if (lvl == 0 || lvl + int'(cfg_shadow.hysteresis) < thr) begin
               sw_on = 1'b0;
            end
            if (!quiet) begin
               push_rsp(OUT_KIND_REPORT, 8'h00, 1'b1);
            end
         end
         KIND_POWER: begin
            if (sv <= POWER_MAX) begin
               power_lvl = sv[POWER_WIDTH-1:0];
            end
         end
         default: begin
            if (sv <= 16'(PRIORITY_MAX)) begin
               prio_lvl = sv[6:0];
            end
         end
      endcase
   endtask

   task automatic send_item(in_kind_type k, logic [7:0] lb, logic [7:0] lv,
                            logic [15:0] sv, bit quiet);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_kind <= k;
      req_link_byte <= lb;
      req_level_sample <= lv;
      req_setting_value <= sv;
      do @(posedge clock); while (req_full);
      predict_item(k, lb, lv, sv, quiet);
      n_in++;
   endtask

   task automatic send_link(logic [7:0] b);
      send_item(KIND_LINK, b, 8'($urandom), 16'($urandom), 1'b0);
   endtask

   task automatic send_frame();
      logic [7:0] body[$];
      int n;
      bit broken;
      n = ($urandom_range(0, 99) < 60) ? 3 : $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
         body.push_back(8'($urandom));
      end
      if ($urandom_range(0, 99) < 70) begin
         if (n > 0) body[0] = cfg_shadow.group_id;
         if (n > 1) body[1] = cfg_shadow.node_id;
         if (n > 2) body[2] = cfg_shadow.poll_code;
      end
      broken = ($urandom_range(0, 99) < 15);
      send_link(cfg_shadow.start_code);
      foreach (body[i]) begin
         if (body[i] == cfg_shadow.escape_code || body[i] == cfg_shadow.end_code ||
             $urandom_range(0, 9) == 0) begin
            send_link(cfg_shadow.escape_code);
            send_link(body[i] ^ ESC_FLIP);
         end else begin
            send_link(body[i]);
         end
      end
      if (!broken) begin
         send_link(cfg_shadow.end_code);
      end else if ($urandom_range(0, 1) == 1) begin
         send_link(cfg_shadow.escape_code);
      end
   endtask

   task automatic write_reg(logic [7:0] idx, logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GROUP_ID: cfg_shadow.group_id = data;
         REG_NODE_ID: cfg_shadow.node_id = data;
         REG_POLL_CODE: cfg_shadow.poll_code = data;
         REG_REPLY_CODE: cfg_shadow.reply_code = data;
         REG_START_CODE: cfg_shadow.start_code = data;
         REG_ESCAPE_CODE: cfg_shadow.escape_code = data;
         REG_END_CODE: cfg_shadow.end_code = data;
         REG_HYSTERESIS: cfg_shadow.hysteresis = data[6:0];
         default: ;
      endcase
      n_csr++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [7:0] grp, logic [7:0] node, logic [7:0] poll,
                            logic [7:0] rcode, logic [7:0] scode, logic [7:0] ecode,
                            logic [7:0] fcode, logic [7:0] hyst);
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      write_reg(REG_GROUP_ID, grp);
      write_reg(REG_NODE_ID, node);
      write_reg(REG_POLL_CODE, poll);
      write_reg(REG_REPLY_CODE, rcode);
      write_reg(REG_START_CODE, scode);
      write_reg(REG_ESCAPE_CODE, ecode);
      write_reg(REG_END_CODE, fcode);
      write_reg(REG_HYSTERESIS, hyst);
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int idle_left;
      idle_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            idle_left = HOLD_CYCLES;
         end
         if (idle_left > 0) begin
            rsp_pop <= 1'b0;
            idle_left--;
         end else begin
            rsp_pop <= 1'b1;
            idle_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && req_push && req_full) begin
         n_full_cycles++;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         got.out_kind = rsp_out_kind;
         got.reply_byte = rsp_reply_byte;
         got.last = rsp_last;
         got.switch_on = rsp_switch_on;
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer: out_kind %0d reply_byte 0x%02h",
                   got.out_kind, got.reply_byte);
            err_cnt++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.out_kind !== want.out_kind) begin
               $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
               err_cnt++;
            end
            if (got.reply_byte !== want.reply_byte) begin
               $error("reply_byte: expected 0x%02h, got 0x%02h",
                      want.reply_byte, got.reply_byte);
               err_cnt++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               err_cnt++;
            end
            if (got.switch_on !== want.switch_on) begin
               $error("switch_on: expected %0d, got %0d", want.switch_on, got.switch_on);
               err_cnt++;
            end
         end
      end
   end

   initial begin
      int r;
      int phase_cnt;
      reset = 1'b1;
      req_push = 1'b0;
      req_kind = KIND_LINK;
      req_link_byte = 8'h00;
      req_level_sample = 8'h00;
      req_setting_value = 16'h0000;
      csr_valid = 1'b0;
      csr_index = 8'h00;
      csr_data = 8'h00;

      cfg_shadow = '{group_id: 8'd0, node_id: 8'd0, poll_code: 8'd0, reply_code: 8'd0,
                     start_code: 8'd2, escape_code: 8'd16, end_code: 8'd3,
                     hysteresis: 7'd5};
      df_state = DF_HUNT;
      payload_cnt = 2'd0;
      hdr_group = 8'h00;
      hdr_node = 8'h00;
      hdr_type = 8'h00;
      power_lvl = '0;
      prio_lvl = 7'd100;
      sw_on = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         send_item(dir_tab[i].kind, dir_tab[i].link_byte, dir_tab[i].level,
                   dir_tab[i].setting, dir_tab[i].known);
         if (dir_tab[i].known) begin
            push_rsp(OUT_KIND_REPORT, 8'h00, 1'b1);
            pending_rsp[pending_rsp.size() - 1].switch_on = dir_tab[i].known_sw;
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00);
            1: configure(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfd, 8'hff);
            4: begin
               r = $urandom_range(0, 255);
               configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'(r), 8'(r), 8'($urandom_range(0, 100)));
            end
            default: configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(0, 100)));
         endcase
         if (ph == 2) begin
            write_reg(8'($urandom_range(int'(REG_HYSTERESIS) + 1, 255)), 8'($urandom));
            hold_req = 1'b1;
         end
         no_idle = (ph == 3);
         phase_cnt = n_in;
         while (n_in - phase_cnt < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               send_frame();
            end else if (r < 75) begin
               send_item(KIND_LEVEL, 8'($urandom),
                         ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 100))
                                                     : 8'($urandom),
                         16'($urandom), 1'b0);
            end else if (r < 85) begin
               send_item(KIND_POWER, 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4095))
                                                    : 16'($urandom), 1'b0);
            end else if (r < 93) begin
               send_item(KIND_PRIORITY, 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 100))
                                                    : 16'($urandom), 1'b0);
            end else begin
               repeat ($urandom_range(1, 3)) send_link(8'($urandom));
            end
         end
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d input transfers and %0d register writes over %0d settings.",
               n_in, n_csr, NUM_PHASES + 1);
      $display("Checked %0d result transfers, %0d poll replies, %0d cycles with input stalled.",
               n_rsp, n_replies, n_full_cycles);
      if (err_cnt == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> framed_poll_responder_load_switch.f
rtl/fprls_pkg.sv
rtl/fprls_csr.sv
rtl/fprls_front.sv
rtl/fprls_jobq.sv
rtl/fprls_back.sv
rtl/framed_poll_responder_load_switch.sv
verif/tb.sv
